[src/potential_gradient_3d_stencil_defines.svh]
// Assertion macros for the potential-gradient stencil block.
// The using scope must provide the signals clk and rst.
`ifndef POTENTIAL_GRADIENT_3D_STENCIL_DEFINES_SVH
`define POTENTIAL_GRADIENT_3D_STENCIL_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PGS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PGS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/pgs_pkg.sv]
// Shared constants, types and stencil helper functions of the potential-gradient block.
// Used by every RTL module; depends on nothing.
package pgs_pkg;

  localparam int MaxDim  = 32;
  localparam int NumAxes = 3;
  localparam int AxisW   = 2;
  localparam int TapW    = 2;
  localparam int CoordW  = $clog2(MaxDim);
  localparam int SizeW   = $clog2(MaxDim + 1);
  localparam int AddrW   = NumAxes * CoordW;
  localparam int Depth   = MaxDim * MaxDim * MaxDim;
  localparam int WordW   = 32;
  localparam int HalfW   = WordW / 2;
  localparam int SumW    = WordW + 3;
  localparam int CfgIdxW = 2;

  localparam logic [SizeW-1:0] SizeMin   = SizeW'(3);
  localparam logic [SizeW-1:0] SizeMax   = SizeW'(MaxDim);
  localparam logic [WordW-1:0] ScaleOne  = WordW'(1) << HalfW;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_SIZE_X     = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_SIZE_Y     = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_SIZE_Z     = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_INV_TWO_DX = 2'd3;

  // Request types.
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Last axis index.
  localparam logic [AxisW-1:0] AXIS_LAST = AxisW'(NumAxes - 1);

  typedef enum logic [1:0] {
    MODE_LOW,
    MODE_HIGH,
    MODE_MID
  } axis_mode_t;

  typedef enum logic [2:0] {
    COEF_P1,
    COEF_M1,
    COEF_P3,
    COEF_M3,
    COEF_P4,
    COEF_M4
  } coef_t;

  typedef struct packed {
    logic [SizeW-1:0] size_x;
    logic [SizeW-1:0] size_y;
    logic [SizeW-1:0] size_z;
    logic [WordW-1:0] inv_two_dx;
  } cfg_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] addr;
    logic [WordW-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic                   valid;
    logic [AxisW-1:0]       axis;
    logic signed [SumW-1:0] sum;
  } scale_req_t;

  typedef struct packed {
    logic                    valid;
    logic [AxisW-1:0]        axis;
    logic signed [WordW-1:0] value;
  } scale_res_t;

  typedef struct packed {
    logic signed [WordW-1:0] field_x;
    logic signed [WordW-1:0] field_y;
    logic signed [WordW-1:0] field_z;
    logic                    covered;
  } result_t;

  // Clamp a size register to the usable range.
  function automatic logic [SizeW-1:0] eff_size(input logic [SizeW-1:0] s);
    logic [SizeW-1:0] r;
    r = s;
    if (s < SizeMin) begin
      r = SizeMin;
    end else if (s > SizeMax) begin
      r = SizeMax;
    end
    return r;
  endfunction

  // Grid index along the working axis for one stencil tap.
  function automatic logic [CoordW-1:0] tap_coord(input axis_mode_t m,
                                                  input logic [TapW-1:0] tap,
                                                  input logic [CoordW-1:0] p,
                                                  input logic [SizeW-1:0] n);
    logic [SizeW-1:0] v;
    case (m)
      MODE_LOW:  v = SizeW'(tap);
      MODE_HIGH: v = n - SizeW'(3) + SizeW'(tap);
      MODE_MID:  v = SizeW'(p) + SizeW'({tap, 1'b0}) - SizeW'(1);
      default:   v = '0;
    endcase
    return v[CoordW-1:0];
  endfunction

  // Weight of one stencil tap.
  function automatic coef_t tap_coef(input axis_mode_t m, input logic [TapW-1:0] tap);
    coef_t c;
    c = COEF_P1;
    case (m)
      MODE_LOW: begin
        c = (tap == TapW'(0)) ? COEF_P3 : (tap == TapW'(1)) ? COEF_M4 : COEF_P1;
      end
      MODE_HIGH: begin
        c = (tap == TapW'(0)) ? COEF_M1 : (tap == TapW'(1)) ? COEF_P4 : COEF_M3;
      end
      MODE_MID: begin
        c = (tap == TapW'(0)) ? COEF_P1 : COEF_M1;
      end
      default: c = COEF_P1;
    endcase
    return c;
  endfunction

  function automatic logic tap_last(input axis_mode_t m, input logic [TapW-1:0] tap);
    return (m == MODE_MID) ? (tap == TapW'(1)) : (tap == TapW'(2));
  endfunction

  // Weighted sample, widened so that a full three-tap sum cannot overflow.
  function automatic logic signed [SumW-1:0] tap_term(input logic signed [WordW-1:0] d,
                                                      input coef_t c);
    logic signed [SumW-1:0] x;
    logic signed [SumW-1:0] r;
    x = {{(SumW - WordW){d[WordW-1]}}, d};
    case (c)
      COEF_P1: r = x;
      COEF_M1: r = -x;
      COEF_P3: r = (x <<< 1) + x;
      COEF_M3: r = -((x <<< 1) + x);
      COEF_P4: r = x <<< 2;
      COEF_M4: r = -(x <<< 2);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[src/pgs_grid_mem.sv]
// Single-port synchronous grid memory with a registered read.
// Depends on pgs_pkg for the address and word widths.
module pgs_grid_mem (
  input  logic                      clk,
  input  pgs_pkg::mem_req_t         req,
  output logic [pgs_pkg::WordW-1:0] rdata
);
  import pgs_pkg::*;

  logic [WordW-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rdata <= mem[req.addr];
  end

endmodule

[src/pgs_scale.sv]
// Three-stage unit that scales a stencil sum by the Q16.16 reciprocal and saturates.
// Depends on pgs_pkg for the request and result types.
module pgs_scale (
  input  logic                      clk,
  input  logic                      rst,
  input  pgs_pkg::scale_req_t       req,
  input  logic [pgs_pkg::WordW-1:0] scale,
  output pgs_pkg::scale_res_t       res
);
  import pgs_pkg::*;

  localparam int ProdW = SumW + HalfW;
  localparam int QW    = ProdW + 1;
  localparam logic [QW-1:0] NegLim = QW'(1) << (WordW - 1);
  localparam logic [QW-1:0] PosLim = NegLim - QW'(1);

  logic             a_valid;
  logic [AxisW-1:0] a_axis;
  logic             a_neg;
  logic [SumW-1:0]  a_mag;

  logic             b_valid;
  logic [AxisW-1:0] b_axis;
  logic             b_neg;
  logic [ProdW-1:0] b_hi;
  logic [ProdW-1:0] b_lo;

  logic [QW-1:0]    q;
  logic [WordW-1:0] sat;

  // Sign and magnitude split.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= req.valid;
    end
    a_axis <= req.axis;
    a_neg  <= req.sum[SumW-1];
    a_mag  <= req.sum[SumW-1] ? SumW'(-req.sum) : SumW'(req.sum);
  end

  // Two partial products against the integer and fraction halves.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
    b_axis <= a_axis;
    b_neg  <= a_neg;
    b_hi   <= ProdW'(a_mag) * ProdW'(scale[WordW-1:HalfW]);
    b_lo   <= ProdW'(a_mag) * ProdW'(scale[HalfW-1:0]);
  end

  always_comb begin
    q = QW'(b_hi) + QW'(b_lo >> HalfW);
    if (b_neg) begin
      if (q > NegLim) begin
        sat = NegLim[WordW-1:0];
      end else begin
        sat = '0 - q[WordW-1:0];
      end
    end else begin
      if (q > PosLim) begin
        sat = PosLim[WordW-1:0];
      end else begin
        sat = q[WordW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else begin
      res.valid <= b_valid;
    end
    res.axis  <= b_axis;
    res.value <= sat;
  end

endmodule

[src/pgs_ctrl.sv]
// Sequencer: decodes requests, walks the stencil taps through the grid memory,
// accumulates each axis and gathers the scaled components. Depends on pgs_pkg.
module pgs_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       req_type,
  input  logic [pgs_pkg::CoordW-1:0] coord_x,
  input  logic [pgs_pkg::CoordW-1:0] coord_y,
  input  logic [pgs_pkg::CoordW-1:0] coord_z,
  input  logic [pgs_pkg::WordW-1:0]  phi_value,
  input  pgs_pkg::cfg_t              cfg,
  output pgs_pkg::mem_req_t          mem_req,
  input  logic [pgs_pkg::WordW-1:0]  mem_rdata,
  output pgs_pkg::scale_req_t        scale_req,
  input  pgs_pkg::scale_res_t        scale_res,
  output logic                       res_valid,
  output pgs_pkg::result_t           res,
  input  logic                       res_take
);
  import pgs_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  logic [CoordW-1:0] pos  [NumAxes];
  logic [SizeW-1:0]  dim  [NumAxes];
  axis_mode_t        mode [NumAxes];

  logic [CoordW-1:0] pos_in  [NumAxes];
  logic [SizeW-1:0]  dim_in  [NumAxes];
  axis_mode_t        mode_in [NumAxes];
  logic [NumAxes-1:0] bnd_in;
  logic               skip_in;

  logic [AxisW-1:0] axis;
  logic [TapW-1:0]  tap;
  logic             last_now;
  coef_t            coef_now;
  logic [CoordW-1:0] tap_pos [NumAxes];

  logic             rd_valid;
  logic             rd_first;
  logic             rd_last;
  logic [AxisW-1:0] rd_axis;
  coef_t            rd_coef;

  logic signed [SumW-1:0] acc;
  logic signed [SumW-1:0] acc_next;

  logic [1:0]              done_cnt;
  logic signed [WordW-1:0] field [NumAxes];
  logic                    covered;

  logic accept;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // Query decode from the live input word.
  always_comb begin
    pos_in[0] = coord_x;
    pos_in[1] = coord_y;
    pos_in[2] = coord_z;
    dim_in[0] = eff_size(cfg.size_x);
    dim_in[1] = eff_size(cfg.size_y);
    dim_in[2] = eff_size(cfg.size_z);
    skip_in   = 1'b0;
    for (int a = 0; a < NumAxes; a++) begin
      bnd_in[a] = (pos_in[a] == '0) || (SizeW'(pos_in[a]) == dim_in[a] - SizeW'(1));
      if (SizeW'(pos_in[a]) >= dim_in[a]) begin
        skip_in = 1'b1;
      end
      if (pos_in[a] == '0) begin
        mode_in[a] = MODE_LOW;
      end else if (SizeW'(pos_in[a]) == dim_in[a] - SizeW'(1)) begin
        mode_in[a] = MODE_HIGH;
      end else begin
        mode_in[a] = MODE_MID;
      end
    end
    // Edges and corners lie on the boundary of two or more axes.
    if ((bnd_in[0] && bnd_in[1]) || (bnd_in[0] && bnd_in[2]) || (bnd_in[1] && bnd_in[2])) begin
      skip_in = 1'b1;
    end
  end

  // Tap address for the current read.
  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      tap_pos[a] = pos[a];
    end
    tap_pos[axis] = tap_coord(mode[axis], tap, pos[axis], dim[axis]);
    last_now      = tap_last(mode[axis], tap);
    coef_now      = tap_coef(mode[axis], tap);
  end

  always_comb begin
    mem_req.we    = accept && (req_type == REQ_LOAD);
    mem_req.wdata = phi_value;
    if (state == ST_READ) begin
      mem_req.addr = {tap_pos[0], tap_pos[1], tap_pos[2]};
    end else begin
      mem_req.addr = {coord_x, coord_y, coord_z};
    end
  end

  always_comb begin
    acc_next = rd_first ? tap_term(signed'(mem_rdata), rd_coef)
                        : acc + tap_term(signed'(mem_rdata), rd_coef);
    scale_req.valid = rd_valid && rd_last;
    scale_req.axis  = rd_axis;
    scale_req.sum   = acc_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (req_type == REQ_QUERY)) begin
          state_next = skip_in ? ST_DONE : ST_READ;
        end
      end
      ST_READ: begin
        if (last_now && (axis == AXIS_LAST)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (scale_res.valid && (done_cnt == 2'd2)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      axis     <= '0;
      tap      <= '0;
      rd_valid <= 1'b0;
      done_cnt <= '0;
    end else begin
      state    <= state_next;
      rd_valid <= (state == ST_READ);
      if (accept) begin
        axis     <= '0;
        tap      <= '0;
        done_cnt <= '0;
      end else begin
        if (state == ST_READ) begin
          if (last_now) begin
            tap  <= '0;
            axis <= axis + AxisW'(1);
          end else begin
            tap <= tap + TapW'(1);
          end
        end
        if (scale_res.valid) begin
          done_cnt <= done_cnt + 2'd1;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    rd_axis  <= axis;
    rd_coef  <= coef_now;
    rd_first <= (tap == '0);
    rd_last  <= last_now;
    if (rd_valid) begin
      acc <= acc_next;
    end
    if (accept && (req_type == REQ_QUERY)) begin
      for (int a = 0; a < NumAxes; a++) begin
        pos[a]   <= pos_in[a];
        dim[a]   <= dim_in[a];
        mode[a]  <= mode_in[a];
        field[a] <= '0;
      end
      covered <= !skip_in;
    end else if (scale_res.valid) begin
      field[scale_res.axis] <= scale_res.value;
    end
  end

  assign res_valid   = (state == ST_DONE);
  assign res.field_x = field[0];
  assign res.field_y = field[1];
  assign res.field_z = field[2];
  assign res.covered = covered;

endmodule

[src/potential_gradient_3d_stencil.sv]
// Top level of the potential-gradient stencil block: configuration registers,
// output register and the sequencer, scaler and grid memory. Depends on pgs_pkg.
//
//   channel | valid    | stall     | word
//   --------+----------+-----------+-------------------------------------------
//   input   | in_valid | in_stall  | req_type, coord_x/y/z, phi_value
//   output  | out_valid| out_stall | field_x/y/z, point_covered
//   config  | cfg_write| (none)    | cfg_index, cfg_data
//
// A load word is written into the grid memory at its acceptance edge and keeps
// in_stall low, so loads stream at one word per cycle.
// A covered query makes one memory read per cycle through the single grid port
// (six reads inside the grid, seven on a face); the sums then pass the registered
// memory output and the three scaler stages before the result word is offered,
// and in_stall stays high until the word moves into the output register. An edge,
// corner or outside query offers its all-zero word in the cycle after acceptance.
// The output register frees the sequencer as soon as the word is handed over,
// so a new word can be accepted while out_stall holds the previous result.
// Reset (rst, synchronous) clears the control state and restores the register
// defaults; the grid memory is not cleared and holds undefined data until loaded.
module potential_gradient_3d_stencil (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              req_type,
  input  logic [pgs_pkg::CoordW-1:0]        coord_x,
  input  logic [pgs_pkg::CoordW-1:0]        coord_y,
  input  logic [pgs_pkg::CoordW-1:0]        coord_z,
  input  logic signed [pgs_pkg::WordW-1:0]  phi_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [pgs_pkg::WordW-1:0]  field_x,
  output logic signed [pgs_pkg::WordW-1:0]  field_y,
  output logic signed [pgs_pkg::WordW-1:0]  field_z,
  output logic                              point_covered,
  input  logic                              cfg_write,
  input  logic [pgs_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [pgs_pkg::WordW-1:0]         cfg_data
);
  import pgs_pkg::*;

  cfg_t             cfg;
  mem_req_t         mem_req;
  logic [WordW-1:0] mem_rdata;
  scale_req_t       scale_req;
  scale_res_t       scale_res;
  logic             res_valid;
  result_t          res;
  logic             res_take;

  // Configuration registers. The user must write them only while the block is idle; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.size_x     <= SizeMax;
      cfg.size_y     <= SizeMax;
      cfg.size_z     <= SizeMax;
      cfg.inv_two_dx <= ScaleOne;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SIZE_X:     cfg.size_x     <= cfg_data[SizeW-1:0];
        REG_SIZE_Y:     cfg.size_y     <= cfg_data[SizeW-1:0];
        REG_SIZE_Z:     cfg.size_z     <= cfg_data[SizeW-1:0];
        REG_INV_TWO_DX: cfg.inv_two_dx <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  pgs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .coord_x   (coord_x),
    .coord_y   (coord_y),
    .coord_z   (coord_z),
    .phi_value (phi_value),
    .cfg       (cfg),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .scale_req (scale_req),
    .scale_res (scale_res),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  pgs_grid_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  pgs_scale u_scale (
    .clk   (clk),
    .rst   (rst),
    .req   (scale_req),
    .scale (cfg.inv_two_dx),
    .res   (scale_res)
  );

  // The output register takes a new word whenever it is empty or being drained.
  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      field_x       <= res.field_x;
      field_y       <= res.field_y;
      field_z       <= res.field_z;
      point_covered <= res.covered;
    end
  end

endmodule

[src/pgs_checker.sv]
// Port-level checker for the potential-gradient stencil block and its bind.
// Depends on pgs_pkg and the assertion macros header.
`include "potential_gradient_3d_stencil_defines.svh"

module pgs_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             req_type,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic signed [pgs_pkg::WordW-1:0] field_x,
  input logic signed [pgs_pkg::WordW-1:0] field_y,
  input logic signed [pgs_pkg::WordW-1:0] field_z,
  input logic                             point_covered
);
  import pgs_pkg::*;

  // A stalled result word must hold.
  `PGS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(field_x) && $stable(field_y) && $stable(field_z) && $stable(point_covered), "result word changed while stalled")

  // A point that is not covered reports a zero field.
  `PGS_ASSERT_SAME(a_uncovered_zero, out_valid && !point_covered, (field_x == '0) && (field_y == '0) && (field_z == '0), "uncovered point with nonzero field")

  // An accepted query occupies the block for at least the next cycle.
  `PGS_ASSERT_NEXT(a_query_busy, in_valid && !in_stall && (req_type == REQ_QUERY), in_stall, "query accepted without holding off input")

  // A load never causes a result word.
  `PGS_ASSERT_NEXT(a_load_silent, in_valid && !in_stall && (req_type == REQ_LOAD), !$rose(out_valid), "result word appeared after a load")

endmodule

bind potential_gradient_3d_stencil pgs_checker u_pgs_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .req_type      (req_type),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .field_x       (field_x),
  .field_y       (field_y),
  .field_z       (field_z),
  .point_covered (point_covered)
);

[dv/potential_gradient_3d_stencil_checker.sv]
// Checker for the potential-gradient stencil block: mirrors the grid and the
// configuration registers, predicts each field word and compares it with the output.
// Depends on pgs_pkg for widths, register indexes, request types and the result type.
module potential_gradient_3d_stencil_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic                              req_type,
  input  logic [pgs_pkg::CoordW-1:0]        coord_x,
  input  logic [pgs_pkg::CoordW-1:0]        coord_y,
  input  logic [pgs_pkg::CoordW-1:0]        coord_z,
  input  logic signed [pgs_pkg::WordW-1:0]  phi_value,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic signed [pgs_pkg::WordW-1:0]  field_x,
  input  logic signed [pgs_pkg::WordW-1:0]  field_y,
  input  logic signed [pgs_pkg::WordW-1:0]  field_z,
  input  logic                              point_covered,
  input  logic                              cfg_write,
  input  logic [pgs_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [pgs_pkg::WordW-1:0]         cfg_data,
  output int                                fault_count,
  output int                                backlog
);
  timeunit 1ns;
  timeprecision 1ps;
  import pgs_pkg::*;

  logic [WordW-1:0] grid [0:Depth-1];
  logic [SizeW-1:0] span_x;
  logic [SizeW-1:0] span_y;
  logic [SizeW-1:0] span_z;
  logic [WordW-1:0] scale_reg;
  result_t          pending_fields [$];
  result_t          want;
  int               faults = 0;

  function automatic int clamp_size(input logic [SizeW-1:0] s);
    if (s < 3) return 3;
    if (s > MaxDim) return MaxDim;
    return int'(s);
  endfunction

  function automatic longint word_at(input int x, input int y, input int z);
    logic signed [WordW-1:0] w;
    w = grid[(x * MaxDim + y) * MaxDim + z];
    return w;
  endfunction

  // Sample on the line through (x, y, z) along one axis, at index v.
  function automatic longint along(input int x, input int y, input int z,
                                   input int axis, input int v);
    if (axis == 0) return word_at(v, y, z);
    if (axis == 1) return word_at(x, v, z);
    return word_at(x, y, v);
  endfunction

  // Negative difference along one axis, still scaled by twice the spacing.
  function automatic longint slope_sum(input int x, input int y, input int z,
                                       input int axis, input int n);
    int p;
    p = (axis == 0) ? x : (axis == 1) ? y : z;
    if (p == 0)
      return 3 * along(x, y, z, axis, 0) - 4 * along(x, y, z, axis, 1)
             + along(x, y, z, axis, 2);
    if (p == n - 1)
      return -along(x, y, z, axis, n - 3) + 4 * along(x, y, z, axis, n - 2)
             - 3 * along(x, y, z, axis, n - 1);
    return along(x, y, z, axis, p - 1) - along(x, y, z, axis, p + 1);
  endfunction

  // Multiply by the Q16.16 scale, truncate toward zero, saturate to 32 bits.
  function automatic logic [WordW-1:0] scale_clip(input longint s);
    longint unsigned m;
    longint unsigned q;
    longint unsigned hi;
    longint unsigned lo;
    logic [63:0]     neg_q;
    hi = scale_reg >> HalfW;
    lo = scale_reg & 32'h0000_FFFF;
    m  = (s < 0) ? -s : s;
    q  = m * hi + ((m * lo) >> HalfW);
    if (s < 0) begin
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      neg_q = -q;
      return neg_q[WordW-1:0];
    end
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    return q[WordW-1:0];
  endfunction

  function automatic result_t field_at(input int x, input int y, input int z);
    result_t r;
    int      nx;
    int      ny;
    int      nz;
    int      rim;
    r   = '0;
    nx  = clamp_size(span_x);
    ny  = clamp_size(span_y);
    nz  = clamp_size(span_z);
    rim = 0;
    if (x >= nx || y >= ny || z >= nz) return r;
    if (x == 0 || x == nx - 1) rim++;
    if (y == 0 || y == ny - 1) rim++;
    if (z == 0 || z == nz - 1) rim++;
    // Edges and corners are not covered by any stencil.
    if (rim >= 2) return r;
    r.field_x = scale_clip(slope_sum(x, y, z, 0, nx));
    r.field_y = scale_clip(slope_sum(x, y, z, 1, ny));
    r.field_z = scale_clip(slope_sum(x, y, z, 2, nz));
    r.covered = 1'b1;
    return r;
  endfunction

  task automatic flag(input string what, input logic [WordW-1:0] want_v,
                      input logic [WordW-1:0] got_v);
    faults++;
    $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want_v, got_v);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      span_x    = SizeW'(MaxDim);
      span_y    = SizeW'(MaxDim);
      span_z    = SizeW'(MaxDim);
      scale_reg = ScaleOne;
      pending_fields.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_SIZE_X:     span_x = cfg_data[SizeW-1:0];
          REG_SIZE_Y:     span_y = cfg_data[SizeW-1:0];
          REG_SIZE_Z:     span_z = cfg_data[SizeW-1:0];
          REG_INV_TWO_DX: scale_reg = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (pending_fields.size() == 0) begin
          faults++;
          $display("%0t: unexpected result word, expected nothing, actual %h %h %h %b",
                   $time, field_x, field_y, field_z, point_covered);
        end else begin
          want = pending_fields.pop_front();
          if (want.field_x !== field_x) flag("field_x", want.field_x, field_x);
          if (want.field_y !== field_y) flag("field_y", want.field_y, field_y);
          if (want.field_z !== field_z) flag("field_z", want.field_z, field_z);
          if (want.covered !== point_covered)
            flag("point_covered", want.covered, point_covered);
        end
      end
      if (in_valid && !in_stall) begin
        if (req_type == REQ_LOAD)
          grid[{coord_x, coord_y, coord_z}] = phi_value;
        else
          pending_fields = {pending_fields, field_at(coord_x, coord_y, coord_z)};
      end
    end
    fault_count <= faults;
    backlog     <= pending_fields.size();
  end

endmodule

[dv/potential_gradient_3d_stencil_test.sv]
// Top of the potential-gradient stencil testbench: clock, reset, stimulus and verdict.
// Depends on pgs_pkg, the block itself and potential_gradient_3d_stencil_checker.
module potential_gradient_3d_stencil_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pgs_pkg::*;

  // Cycles to wait after the last result before touching the registers, as a margin
  // for a covered query that is still running.
  localparam int SettleCycles  = 16;
  localparam int NumPhases     = 7;
  localparam int ItemsPerPhase = 160;

  // How potential samples are drawn.
  localparam int PhiWide    = 0;
  localparam int PhiExtreme = 1;
  localparam int PhiNear    = 2;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic                    req_type = REQ_LOAD;
  logic [CoordW-1:0]       coord_x = '0;
  logic [CoordW-1:0]       coord_y = '0;
  logic [CoordW-1:0]       coord_z = '0;
  logic signed [WordW-1:0] phi_value = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [WordW-1:0] field_x;
  logic signed [WordW-1:0] field_y;
  logic signed [WordW-1:0] field_z;
  logic                    point_covered;
  logic                    cfg_write = 1'b0;
  logic [CfgIdxW-1:0]      cfg_index = REG_SIZE_X;
  logic [WordW-1:0]        cfg_data = '0;

  int fault_count;
  int backlog;

  // Grid entries that have been loaded since reset. A query is only sent once
  // every sample its stencil touches is in here.
  bit loaded [0:Depth-1];
  // Sizes the block is using right now, after clamping to 3..MaxDim.
  int used_size [3] = '{MaxDim, MaxDim, MaxDim};
  int words_sent = 0;
  // When set, the corresponding side runs without idle cycles for a while.
  bit in_quiet = 1'b0;
  bit out_quiet = 1'b0;

  potential_gradient_3d_stencil dut (.*);
  potential_gradient_3d_stencil_checker field_checker (.*);

  always #5 clk = ~clk;

  function automatic int grid_slot(input int x, input int y, input int z);
    return (x * MaxDim + y) * MaxDim + z;
  endfunction

  function automatic int usable(input logic [SizeW-1:0] s);
    if (s < 3) return 3;
    if (s > MaxDim) return MaxDim;
    return int'(s);
  endfunction

  function automatic logic [WordW-1:0] draw_phi(input int style);
    logic [WordW-1:0] v;
    case (style)
      PhiWide: v = $urandom;
      PhiExtreme: begin
        case ($urandom_range(0, 4))
          0: v = 32'h7FFF_FFFF;
          1: v = 32'h8000_0000;
          2: v = '0;
          3: v = '1;
          default: v = $urandom;
        endcase
      end
      default: v = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
    endcase
    return v;
  endfunction

  // Coordinates lean toward the faces, where the one-sided stencils live. The
  // full-range pick can land outside the used grid when the size is below 32.
  function automatic int draw_coord(input int n);
    case ($urandom_range(0, 9))
      0: return 0;
      1: return n - 1;
      2: return 1;
      3: return n - 2;
      4: return $urandom_range(0, MaxDim - 1);
      default: return $urandom_range(0, n - 1);
    endcase
  endfunction

  // Size register words: random upper bits, low bits below, inside and above range.
  function automatic logic [WordW-1:0] draw_size();
    return ($urandom & 32'hFFFF_FFC0) | $urandom_range(0, 40);
  endfunction

  function automatic logic [WordW-1:0] draw_scale();
    case ($urandom_range(0, 2))
      0: return $urandom;
      1: return $urandom_range(0, 32'h0003_FFFF);
      default: return ScaleOne;
    endcase
  endfunction

  // Offer one word on the input channel and hold it until it is taken. A gap of
  // idle cycles comes first unless the sender is in a quiet stretch. On return
  // valid is still high, so the caller either sends the next word right away or
  // calls settle, which lowers it in the same time step.
  task automatic send_word(input logic kind, input int x, input int y, input int z,
                           input logic [WordW-1:0] phi);
    int gap;
    if ($urandom_range(0, 47) == 0) in_quiet = !in_quiet;
    gap = in_quiet ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    req_type  <= kind;
    coord_x   <= CoordW'(x);
    coord_y   <= CoordW'(y);
    coord_z   <= CoordW'(z);
    phi_value <= phi;
    do @(posedge clk); while (in_stall);
    if (kind == REQ_LOAD) loaded[grid_slot(x, y, z)] = 1'b1;
    words_sent++;
  endtask

  // Query one point. For a covered point, the samples its stencil reads are
  // loaded first: all of them when fresh is set, otherwise only those that were
  // never loaded. Outside points, edges and corners read nothing, so they go
  // straight out as a query.
  task automatic query_point(input int x, input int y, input int z, input bit fresh,
                             input int style);
    int pos [3];
    int c [3];
    int n;
    int p;
    int t;
    int span;
    int rim;
    bit outside;
    pos     = '{x, y, z};
    rim     = 0;
    outside = 1'b0;
    for (int a = 0; a < 3; a++) begin
      if (pos[a] >= used_size[a]) outside = 1'b1;
      else if (pos[a] == 0 || pos[a] == used_size[a] - 1) rim++;
    end
    if (!outside && rim < 2) begin
      for (int a = 0; a < 3; a++) begin
        n    = used_size[a];
        p    = pos[a];
        span = (p == 0 || p == n - 1) ? 3 : 2;
        for (int k = 0; k < span; k++) begin
          if (p == 0) t = k;
          else if (p == n - 1) t = n - 3 + k;
          else t = (k == 0) ? p - 1 : p + 1;
          c    = pos;
          c[a] = t;
          if (fresh || !loaded[grid_slot(c[0], c[1], c[2])])
            send_word(REQ_LOAD, c[0], c[1], c[2], draw_phi(style));
        end
      end
    end
    // The sample field is ignored on a query, so it carries random bits.
    send_word(REQ_QUERY, x, y, z, $urandom);
  endtask

  // Drop valid and wait until every outstanding result has been taken, then a
  // little longer in case the block is still finishing a query that gives no
  // result yet. The first edge lets the checker count the last accepted query.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Write all four registers on consecutive cycles. Only called while idle.
  task automatic configure_grid(input logic [WordW-1:0] sx, input logic [WordW-1:0] sy,
                                input logic [WordW-1:0] sz, input logic [WordW-1:0] inv);
    cfg_write <= 1'b1;
    cfg_index <= REG_SIZE_X;
    cfg_data  <= sx;
    @(posedge clk);
    cfg_index <= REG_SIZE_Y;
    cfg_data  <= sy;
    @(posedge clk);
    cfg_index <= REG_SIZE_Z;
    cfg_data  <= sz;
    @(posedge clk);
    cfg_index <= REG_INV_TWO_DX;
    cfg_data  <= inv;
    @(posedge clk);
    cfg_write <= 1'b0;
    used_size[0] = usable(sx[SizeW-1:0]);
    used_size[1] = usable(sy[SizeW-1:0]);
    used_size[2] = usable(sz[SizeW-1:0]);
  endtask

  // The receiver stalls each result for a random number of cycles, except in
  // quiet stretches where it takes every word as soon as it is offered.
  initial begin : result_sink
    int hold;
    forever begin
      if ($urandom_range(0, 31) == 0) out_quiet = !out_quiet;
      hold = out_quiet ? 0 : $urandom_range(0, 18);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    int goal;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed words with the reset sizes of 32 on every axis and unit scale.
    // Samples at the rails of the Q16.16 range push the sums into saturation.
    // Low face on x: one-sided stencil along x, central along y and z.
    query_point(0, 5, 7, 1'b1, PhiExtreme);
    // Interior neighbor, reusing the samples on the x line.
    query_point(1, 5, 7, 1'b0, PhiExtreme);
    // High face on x at the top coordinate.
    query_point(31, 16, 16, 1'b1, PhiExtreme);
    // A corner and an edge give zero fields with the covered flag clear.
    query_point(31, 31, 31, 1'b0, PhiWide);
    query_point(0, 31, 9, 1'b0, PhiWide);

    // Each phase programs a new grid shape and scale, then runs a random mix:
    // mostly load-then-query sequences, with re-queries over loaded samples and
    // stray loads that overwrite samples other stencils depend on. Between
    // phases everything drains before the registers change.
    goal = 0;
    for (int phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0: ;  // keep the reset values
        // Sizes below the minimum act as 3, and a zero scale zeroes every field.
        1: configure_grid(32'd1, 32'd0, 32'd2, 32'd0);
        // Sizes above the maximum act as 32; the largest scale saturates often.
        2: configure_grid(32'd63, 32'd5, 32'hFFFF_FFD1, 32'hFFFF_FFFF);
        3: configure_grid(32'd3, 32'd32, 32'd4, ScaleOne);
        default: configure_grid(draw_size(), draw_size(), draw_size(), draw_scale());
      endcase
      goal += ItemsPerPhase;
      while (words_sent < goal) begin
        if ($urandom_range(0, 99) < 85)
          query_point(draw_coord(used_size[0]), draw_coord(used_size[1]),
                      draw_coord(used_size[2]), $urandom_range(0, 1),
                      $urandom_range(PhiWide, PhiNear));
        else
          send_word(REQ_LOAD, $urandom_range(0, MaxDim - 1), $urandom_range(0, MaxDim - 1),
                    $urandom_range(0, MaxDim - 1), $urandom);
        // Now and then the sender holds off until the block has drained.
        if ($urandom_range(0, 39) == 0) settle();
      end
      settle();
    end

    if (fault_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // A correct run needs well under a tenth of this; a hang ends here.
  initial begin : watchdog
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
